FILE: src/cokt_pkg.sv
// ----------------------------------------------------------------------------
// cokt_pkg: types and constants of the clock offset kalman tracker
// sample and result beat layouts, register indexes, reset values, widths
// ----------------------------------------------------------------------------
package cokt_pkg;

  // widths of the filter state
  localparam int unsigned VarW  = 17;
  localparam int unsigned DenW  = 18;
  localparam int unsigned TimeW = 64;
  localparam int unsigned MulAW = 32;
  localparam int unsigned MulPW = MulAW + VarW;
  localparam int unsigned DvdW  = 82;
  localparam int unsigned CntW  = 6;

  // shift-subtract passes, two quotient bits each
  localparam logic [CntW-1:0] DIV_PASSES_EST = CntW'(41);
  localparam logic [CntW-1:0] DIV_PASSES_VAR = CntW'(17);

  // configuration register indexes
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd0;
  localparam logic [1:0] CFG_PROC_NOISE = 2'd1;
  localparam logic [1:0] CFG_NET_FLOOR  = 2'd2;

  // register reset values
  localparam logic [15:0] MEAS_NOISE_RST = 16'd4000;
  localparam logic [15:0] PROC_NOISE_RST = 16'd4;
  localparam logic [31:0] NET_FLOOR_RST  = 32'd0;

  // sample commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [TimeW-1:0] LAT_MAX      = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic [TimeW-1:0] LAT_NOTREADY = {TimeW{1'b1}};

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] host_time_us;
    logic [TimeW-1:0] local_time_us;
  } sample_t;

  typedef struct packed {
    logic                    is_ready;
    logic signed [TimeW-1:0] offset_estimate;
    logic signed [TimeW-1:0] offset_floor;
    logic signed [TimeW-1:0] latency_us;
  } result_t;

endpackage

FILE: src/clock_offset_kalman_tracker.sv
// ----------------------------------------------------------------------------
// clock_offset_kalman_tracker: scalar integer kalman filter on clock offset
// tracks local minus host timestamp offset, its floor and reported latency
// ----------------------------------------------------------------------------
//
//  channel   handshake                      beat
//  --------  -----------------------------  -----------------------------------
//  sample    sample_valid / sample_stall    sample_t: cmd, host and local time
//  result    result_valid / result_stall    result_t: ready, estimate, floor,
//                                           latency
//  config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  a filter update runs from the accepted sample beat to the result beat
//  through set-up, two 32x17 partial products, passes of the shared 2-bit
//  shift-subtract divider for the gain step and for the variance step, and
//  bookkeeping. a clear or a seeding sample goes straight to the excess step,
//  a zero denominator skips the divisions. one sample is in flight at a time;
//  sample_stall is high while the sequencer is busy. a waiting result beat
//  does not block the next sample, only the load of the following result.
//  rst is synchronous and restores the register reset values and an empty
//  filter. config writes are always taken.
//
module clock_offset_kalman_tracker
  import cokt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_MUL_LO = 4'd2;
  localparam logic [3:0] S_MUL_HI = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_EST    = 4'd6;
  localparam logic [3:0] S_VAR    = 4'd7;
  localparam logic [3:0] S_FLOOR  = 4'd8;
  localparam logic [3:0] S_EXCESS = 4'd9;
  localparam logic [3:0] S_LAT    = 4'd10;

  logic [3:0] state;

  // configuration registers
  logic [15:0] meas_noise;
  logic [15:0] proc_noise;
  logic [31:0] net_floor;

  // filter state
  logic             have_sample;
  logic [TimeW-1:0] estimate;
  logic [VarW-1:0]  variance;
  logic [TimeW-1:0] lowest;
  logic [TimeW-1:0] last_raw;

  // working registers
  logic [TimeW-1:0] mag;      // innovation magnitude, later the latency excess
  logic             neg;      // raw below estimate
  logic [DenW-1:0]  den;      // variance plus measurement noise
  logic [MulPW-1:0] prod_lo;
  logic [MulPW-1:0] prod_hi;
  logic [DvdW-1:0]  dvd;      // dividend, consumed from the top
  logic [DenW-1:0]  rem;
  logic [TimeW-1:0] quo;
  logic [CntW-1:0]  count;
  logic             div_var;  // second division: variance update

  logic sample_accept;
  logic result_free;

  assign sample_stall  = (state != S_IDLE);
  assign sample_accept = sample_valid && !sample_stall;
  assign cfg_ready     = 1'b1;
  // result register can take a new beat
  assign result_free   = !(result_valid && result_stall);

  // raw offset, modulo 2^64
  logic [TimeW-1:0] raw_offset;
  assign raw_offset = sample.local_time_us - sample.host_time_us;

  // denominator for the update
  logic [DenW-1:0] den_next;
  assign den_next = {1'b0, variance} + DenW'(meas_noise);

  // shared multiplier, 32 x 17
  logic [MulAW-1:0] mul_a;
  logic [MulPW-1:0] mul_p;
  always_comb begin
    unique case (state)
      S_MUL_LO: mul_a = mag[MulAW-1:0];
      S_MUL_HI: mul_a = mag[TimeW-1:MulAW];
      default:  mul_a = MulAW'(meas_noise);
    endcase
  end
  assign mul_p = MulPW'(mul_a) * MulPW'(variance);

  // full 81-bit product of magnitude and variance
  logic [DvdW-2:0] prod_sum;
  assign prod_sum = {prod_hi, {MulAW{1'b0}}} + (DvdW-1)'(prod_lo);

  // two restoring divide steps per cycle
  logic [DenW:0]   t1, t2;
  logic            ge1, ge2;
  logic [DenW-1:0] r1, r2;
  always_comb begin
    t1  = {rem, dvd[DvdW-1]};
    ge1 = (t1 >= {1'b0, den});
    r1  = ge1 ? DenW'(t1 - {1'b0, den}) : t1[DenW-1:0];
    t2  = {r1, dvd[DvdW-2]};
    ge2 = (t2 >= {1'b0, den});
    r2  = ge2 ? DenW'(t2 - {1'b0, den}) : t2[DenW-1:0];
  end

  // latency sum with saturation
  logic [TimeW:0] lat_sum;
  assign lat_sum = {1'b0, mag} + (TimeW+1)'(net_floor);

  logic [TimeW-1:0] lat_value;
  always_comb begin
    priority if (!have_sample) begin
      lat_value = LAT_NOTREADY;
    end else if (lat_sum[TimeW] || lat_sum[TimeW-1]) begin
      lat_value = LAT_MAX;
    end else begin
      lat_value = lat_sum[TimeW-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_noise <= MEAS_NOISE_RST;
      proc_noise <= PROC_NOISE_RST;
      net_floor  <= NET_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MEAS_NOISE: meas_noise <= cfg_data[15:0];
        CFG_PROC_NOISE: proc_noise <= cfg_data[15:0];
        CFG_NET_FLOOR:  net_floor  <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_sample  <= 1'b0;
      estimate     <= '0;
      variance     <= '0;
      lowest       <= '0;
      last_raw     <= '0;
      result_valid <= 1'b0;
    end else begin
      // in S_LAT a leaving beat is replaced by the new one
      if (result_valid && !result_stall && state != S_LAT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_accept) begin
            if (sample.cmd == CMD_CLEAR) begin
              have_sample <= 1'b0;
              estimate    <= '0;
              variance    <= '0;
              lowest      <= '0;
              last_raw    <= '0;
              state       <= S_EXCESS;
            end else begin
              last_raw <= raw_offset;
              if (!have_sample) begin
                // first sample seeds estimate and floor
                have_sample <= 1'b1;
                estimate    <= raw_offset;
                lowest      <= raw_offset;
                variance    <= VarW'(meas_noise);
                state       <= S_EXCESS;
              end else begin
                // predict: variance grows by process noise, wraps at 17 bits
                variance <= variance + VarW'(proc_noise);
                state    <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          den <= den_next;
          if (den_next == '0) begin
            variance <= '0;
            state    <= S_FLOOR;
          end else begin
            neg   <= ($signed(last_raw) < $signed(estimate));
            mag   <= ($signed(last_raw) < $signed(estimate)) ? estimate - last_raw
                                                             : last_raw - estimate;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= mul_p;
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= mul_p;
          state   <= S_ADD;
        end
        S_ADD: begin
          dvd     <= {1'b0, prod_sum};
          rem     <= '0;
          quo     <= '0;
          count   <= DIV_PASSES_EST;
          div_var <= 1'b0;
          state   <= S_DIV;
        end
        S_DIV: begin
          dvd   <= {dvd[DvdW-3:0], 2'b00};
          rem   <= r2;
          quo   <= {quo[TimeW-3:0], ge1, ge2};
          count <= count - CntW'(1);
          if (count == CntW'(1)) begin
            state <= div_var ? S_VAR : S_EST;
          end
        end
        S_EST: begin
          // move estimate by the gain step, then divide variance * noise
          estimate <= neg ? estimate - quo : estimate + quo;
          dvd      <= {1'b0, mul_p[32:0], {(DvdW-34){1'b0}}};
          rem      <= '0;
          quo      <= '0;
          count    <= DIV_PASSES_VAR;
          div_var  <= 1'b1;
          state    <= S_DIV;
        end
        S_VAR: begin
          variance <= quo[VarW-1:0];
          state    <= S_FLOOR;
        end
        S_FLOOR: begin
          if ($signed(estimate) < $signed(lowest)) begin
            lowest <= estimate;
          end
          state <= S_EXCESS;
        end
        S_EXCESS: begin
          // raw excess over floor, limited at zero
          mag   <= ($signed(lowest) < $signed(last_raw)) ? last_raw - lowest : '0;
          state <= S_LAT;
        end
        S_LAT: begin
          if (result_free) begin
            result.is_ready        <= have_sample;
            result.offset_estimate <= estimate;
            result.offset_floor    <= lowest;
            result.latency_us      <= lat_value;
            result_valid           <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the clock offset kalman tracker
// drives sample beats in random bursts, stalls the result channel on a
// pattern of its own, predicts every result with an independent integer
// kalman filter and checks each result beat field by field
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cokt_pkg::*;

  // cycles with no beat on any channel before the run is given up
  localparam int unsigned QuietLimit   = 5000;
  // receiver hold-off length, the sample count that triggers each, and their number
  localparam int unsigned HoldOffLen   = 600;
  localparam int unsigned HoldOffEvery = 500;
  localparam int unsigned HoldOffCount = 2;
  // random part: phases of one register setting each
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseSamples = 190;
  // cycles left to run after the last result
  localparam int unsigned DrainCycles  = 100;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOne = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // dut ports, all inputs known from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample_beat  = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_beat;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = CFG_MEAS_NOISE;
  logic [31:0] cfg_data     = '0;

  // timestamp beats waiting to be driven, reports the tracker still owes
  sample_t timestamp_beats[$];
  result_t reports_due[$];

  // predicted filter registers, tracking the register writes
  logic [15:0] noise_meas = MEAS_NOISE_RST;
  logic [15:0] noise_proc = PROC_NOISE_RST;
  logic [31:0] net_floor  = NET_FLOOR_RST;

  // predicted filter state
  bit          trk_have  = 1'b0;
  logic [63:0] trk_est   = '0;
  logic [VarW-1:0] trk_var = '0;
  logic [63:0] trk_low   = '0;
  logic [63:0] trk_raw   = '0;

  int unsigned mismatches    = 0;
  int unsigned samples_taken = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  int unsigned send_gap   = 0;

  // receiver stall shaping
  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned holdoffs    = 0;

  // random timestamp session: host clock and local minus host skew
  logic [63:0] host_clk = '0;
  logic [63:0] skew     = '0;

  clock_offset_kalman_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // reset asserted from time zero and released once
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one step of the scalar kalman tracker, returns the report it causes
  function automatic result_t kalman_track(input sample_t beat);
    logic [63:0]      raw;
    logic [63:0]      mag;
    logic [63:0]      gain_step;
    logic [63:0]      excess;
    logic [VarW-1:0]  var_pred;
    logic [DenW-1:0]  den;
    logic [127:0]     prod;
    bit               below;
    result_t          rep;
    if (beat.cmd == CMD_CLEAR) begin
      trk_have = 1'b0;
      trk_est  = '0;
      trk_var  = '0;
      trk_low  = '0;
      trk_raw  = '0;
    end else begin
      // offset wraps modulo 2^64, read as two's complement
      raw     = beat.local_time_us - beat.host_time_us;
      trk_raw = raw;
      if (!trk_have) begin
        // first sample seeds estimate and floor
        trk_have = 1'b1;
        trk_est  = raw;
        trk_var  = VarW'(noise_meas);
        trk_low  = raw;
      end else begin
        var_pred = trk_var + VarW'(noise_proc);
        den      = DenW'(var_pred) + DenW'(noise_meas);
        if (den == '0) begin
          // zero noise and zero variance: estimate stays put
          trk_var = '0;
        end else begin
          // innovation taken as sign and magnitude so it never overflows
          below     = $signed(raw) < $signed(trk_est);
          mag       = below ? (trk_est - raw) : (raw - trk_est);
          prod      = 128'(mag) * 128'(var_pred);
          gain_step = 64'(prod / 128'(den));
          trk_est   = below ? (trk_est - gain_step) : (trk_est + gain_step);
          trk_var   = VarW'((40'(var_pred) * 40'(noise_meas)) / 40'(den));
        end
        if ($signed(trk_est) < $signed(trk_low)) trk_low = trk_est;
      end
    end
    rep.is_ready        = trk_have;
    rep.offset_estimate = trk_est;
    rep.offset_floor    = trk_low;
    if (!trk_have) begin
      rep.latency_us = LAT_NOTREADY;
    end else begin
      excess = ($signed(trk_low) < $signed(trk_raw)) ? (trk_raw - trk_low) : '0;
      // saturate the latency at the largest positive int64
      if (excess > LAT_MAX - 64'(net_floor)) rep.latency_us = LAT_MAX;
      else rep.latency_us = excess + 64'(net_floor);
    end
    return rep;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin : sender
    bit offer;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        reports_due.push_back(kalman_track(sample_beat));
        samples_taken++;
      end
      // a stalled beat stays as it is
      if (!sample_valid || !sample_stall) begin
        offer = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
        end else if (timestamp_beats.size() != 0) begin
          sample_beat <= timestamp_beats.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts run straight into the next one
            send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left--;
          end
        end
        sample_valid <= offer;
      end
    end
  end

  // receiver stall pattern, with long hold-offs that back up the sample side
  always @(posedge clk) begin : receiver_stall
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holdoffs < HoldOffCount &&
          samples_taken >= HoldOffEvery * (holdoffs + 1)) begin
        hold_left = HoldOffLen;
        holdoffs++;
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  result_stall <= 1'b0;
          STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
          default:     result_stall <= ~result_stall;
        endcase
      end
    end
  end

  // result checker: each beat against the oldest report due
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h",
                 $time, result_beat);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        check_field("is_ready", 64'(want.is_ready), 64'(result_beat.is_ready));
        check_field("offset_estimate", want.offset_estimate, result_beat.offset_estimate);
        check_field("offset_floor", want.offset_floor, result_beat.offset_floor);
        check_field("latency_us", want.latency_us, result_beat.latency_us);
      end
    end
  end

  // watchdog: ends the run after a long stretch with no beat anywhere
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  task automatic push_sample(input logic cmd, input logic [63:0] host_us,
                             input logic [63:0] local_us);
    timestamp_beats.push_back(sample_t'{cmd, host_us, local_us});
  endtask

  // called right after a rising edge; keeps valid high between writes
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MEAS_NOISE: noise_meas = val[15:0];
      CFG_PROC_NOISE: noise_proc = val[15:0];
      CFG_NET_FLOOR:  net_floor  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] meas, input logic [15:0] proc,
                            input logic [31:0] floor_us);
    cfg_write(CFG_MEAS_NOISE, 32'(meas));
    cfg_write(CFG_PROC_NOISE, 32'(proc));
    cfg_write(CFG_NET_FLOOR, floor_us);
    cfg_valid <= 1'b0;
  endtask

  // sender drained and no report outstanding; returns on a falling edge
  task automatic wait_idle();
    do @(negedge clk);
    while (timestamp_beats.size() != 0 || sample_valid || reports_due.size() != 0);
  endtask

  task automatic new_session();
    logic [31:0] w;
    host_clk = rand64();
    w = $urandom();
    case ($urandom_range(0, 2))
      0:       skew = 64'($urandom_range(0, 2_000_000)) - 64'd1_000_000;
      1:       skew = {{32{w[31]}}, w};
      default: skew = rand64();
    endcase
  endtask

  // mostly steady timestamp streams with jitter and spikes, some noise
  task automatic push_random_sample();
    int unsigned kind;
    logic [63:0] jitter;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      push_sample(CMD_CLEAR, rand64(), rand64());
      new_session();
    end else if (kind < 15) begin
      push_sample(CMD_SAMPLE, rand64(), rand64());
    end else begin
      if (kind < 17) new_session();
      host_clk += 64'($urandom_range(1, 50_000));
      skew     += 64'($urandom_range(0, 6)) - 64'd3;
      jitter    = 64'($urandom_range(0, 2000));
      // occasional late packet
      if ($urandom_range(0, 19) == 0) jitter += 64'($urandom_range(0, 2_000_000));
      push_sample(CMD_SAMPLE, host_clk, host_clk + skew + jitter);
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    do @(posedge clk); while (rst);

    // reset register values: seeding, wrap and wide innovations, saturation
    push_sample(CMD_CLEAR,  AllOne, 64'd0);
    push_sample(CMD_SAMPLE, 64'd0,  64'd0);
    push_sample(CMD_SAMPLE, 64'd0,  MaxPos);
    push_sample(CMD_SAMPLE, MinNeg, 64'd0);
    push_sample(CMD_SAMPLE, 64'd0,  MaxPos);
    push_sample(CMD_SAMPLE, AllOne, AllOne);
    push_sample(CMD_SAMPLE, 64'd1,  64'd0);
    push_sample(CMD_CLEAR,  64'd0,  AllOne);
    push_sample(CMD_SAMPLE, MinNeg, 64'd0);
    push_sample(CMD_SAMPLE, 64'd0,  MaxPos);
    push_sample(CMD_CLEAR,  64'd0,  64'd0);
    push_sample(CMD_SAMPLE, 64'd5,  64'd3);

    // every register at its top value, net floor pushes latency to saturate
    wait_idle();
    @(posedge clk);
    set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    push_sample(CMD_CLEAR,  64'd0,  64'd0);
    push_sample(CMD_SAMPLE, 64'd0,  64'd100);
    push_sample(CMD_SAMPLE, 64'd0,  MaxPos);
    push_sample(CMD_SAMPLE, 64'd10, 64'd5);

    // no noise at all: zero denominator keeps the estimate
    wait_idle();
    @(posedge clk);
    set_config(16'd0, 16'd0, 32'd123);
    push_sample(CMD_CLEAR,  64'd0, 64'd0);
    push_sample(CMD_SAMPLE, 64'd0, 64'd1000);
    push_sample(CMD_SAMPLE, 64'd0, 64'd5000);
    push_sample(CMD_SAMPLE, 64'd7, 64'd2);

    // smallest noise: one half-gain update, then zero variance holds the estimate
    wait_idle();
    @(posedge clk);
    set_config(16'd1, 16'd0, 32'd0);
    push_sample(CMD_CLEAR,  64'd0,  64'd0);
    push_sample(CMD_SAMPLE, 64'd50, 64'd20);
    push_sample(CMD_SAMPLE, 64'd50, MaxPos);
    push_sample(CMD_SAMPLE, MaxPos, 64'd0);

    // random phases, one register setting each, sender drained in between
    new_session();
    for (ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      @(posedge clk);
      case (ph)
        0:       set_config(MEAS_NOISE_RST, PROC_NOISE_RST, NET_FLOOR_RST);
        1:       set_config(16'd1, 16'd0, 32'd0);
        2:       set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        3:       set_config(16'd1, 16'hFFFF, $urandom());
        4:       set_config(16'hFFFF, 16'd0, $urandom());
        default: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                            $urandom());
      endcase
      for (n = 0; n < PhaseSamples; n++) push_random_sample();
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
